/* rtl/b4f16_pkg.sv */
// Shared types and constants for the base-4 short float codec.
// Depends on nothing; every other file in rtl/ imports it.
package b4f16_pkg;

  // Field widths of the two number formats.
  localparam int unsigned DblW  = 64;
  localparam int unsigned BexpW = 11;
  localparam int unsigned FracW = 52;
  localparam int unsigned ExpW  = 4;
  localparam int unsigned MantW = 11;

  // Exponent offset and saturation value of the short format.
  localparam logic [ExpW-1:0]  EXP_OFF = 4'd6;
  localparam logic [ExpW-1:0]  EXP_MAX = 4'd15;
  localparam logic [MantW-1:0] MANT_MAX   = 11'd2047;
  localparam logic [MantW-1:0] MANT_UNDER = 11'd512;

  // All-ones biased exponent of a double: infinity or NaN.
  localparam logic [BexpW-1:0] BEXP_SPECIAL = 11'h7FF;

  // Half of the rounded-up biased exponent at the edges of the short range:
  // below HALF_LOW the short exponent would go negative, above HALF_HIGH past 15.
  localparam logic [BexpW-1:0] HALF_LOW  = 11'd505;
  localparam logic [BexpW-1:0] HALF_HIGH = 11'd520;

  // Biased double exponent of the decoded value is top bit + 2*exp + DEC_BIAS.
  localparam logic [BexpW-1:0] DEC_BIAS = 11'd999;

  // Operation carried in tuser.
  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } b4f16_op_t;

  // One short float.
  typedef struct packed {
    logic             sign;
    logic [ExpW-1:0]  expo;
    logic [MantW-1:0] mant;
  } b4f16_short_t;

endpackage

/* rtl/b4f16_encoder.sv */
// Combinational encoder from a double bit pattern to the base-4 short float.
// Depends on b4f16_pkg.
module b4f16_encoder (
  input  logic [63:0]                dbl,
  output b4f16_pkg::b4f16_short_t    short_o
);
  import b4f16_pkg::*;

  logic [BexpW-1:0] bexp;
  logic [FracW-1:0] frac;
  logic [BexpW:0]   bexp_up;
  logic [BexpW-1:0] half;
  logic [BexpW-1:0] k_full;
  logic [MantW-1:0] mant_norm;

  assign bexp = dbl[62:52];
  assign frac = dbl[51:0];

  // An odd binary exponent is made even by halving the fraction, so the
  // base-4 exponent follows from half the rounded-up biased exponent.
  assign bexp_up   = {1'b0, bexp} + {{BexpW{1'b0}}, 1'b1};
  assign half      = bexp_up[BexpW:1];
  assign k_full    = half - HALF_LOW;
  assign mant_norm = bexp[0] ? {2'b01, frac[51:43]} : {1'b1, frac[51:42]};

  // Special values first, then saturation at either end of the range.
  always_comb begin
    short_o.sign = dbl[63];
    short_o.expo = k_full[ExpW-1:0];
    short_o.mant = mant_norm;
    if ((bexp == BEXP_SPECIAL && frac != '0) || (bexp == '0 && frac == '0)) begin
      short_o.sign = 1'b0;
      short_o.expo = EXP_OFF;
      short_o.mant = '0;
    end else if (bexp == BEXP_SPECIAL || half > HALF_HIGH) begin
      short_o.expo = EXP_MAX;
      short_o.mant = MANT_MAX;
    end else if (bexp == '0 || half < HALF_LOW) begin
      short_o.expo = '0;
      short_o.mant = MANT_UNDER;
    end
  end

endmodule

/* rtl/b4f16_decoder.sv */
// Combinational decoder from the base-4 short float to the mid-point double.
// Depends on b4f16_pkg.
module b4f16_decoder (
  input  b4f16_pkg::b4f16_short_t short_i,
  output logic [63:0]             dbl
);
  import b4f16_pkg::*;

  logic [MantW:0]   q;
  logic [3:0]       top;
  logic [3:0]       lsh;
  logic [MantW:0]   q_norm;
  logic [BexpW-1:0] bexp;

  // Mid-point of the mantissa cell: 2*mant+1, never zero.
  assign q = {short_i.mant, 1'b1};

  // Position of the leading one in the twelve-bit word.
  always_comb begin
    top = '0;
    for (int i = 0; i <= MantW; i++) begin
      if (q[i]) begin
        top = 4'(i);
      end
    end
  end

  // Normalise so the leading one drops out as the hidden bit.
  assign lsh    = 4'(MantW) - top;
  assign q_norm = q << lsh;
  assign bexp   = {7'b0, top} + {6'b0, short_i.expo, 1'b0} + DEC_BIAS;

  assign dbl = {short_i.sign, bexp, q_norm[MantW-1:0], {(FracW-MantW){1'b0}}};

endmodule

/* rtl/base4_float16_codec.sv */
// Top level of the base-4 short float codec: input register, encoder and
// decoder, result register. Depends on b4f16_pkg, b4f16_encoder, b4f16_decoder.
//
// Use of the block:
//   Input words arrive on in_tvalid/in_tready/in_tdata with the operation
//   in in_tuser (0 encode in_tdata's double, 1 decode its short float).
//   Each input word gives exactly one result word on out_tvalid/out_tready/
//   out_tdata. For an encode the double part of the result is zero; for a
//   decode the short float part is zero.
//   A word passes through the input register, then through the conversion
//   logic into the result register, which drives out_tvalid.
//   Throughput is one word per cycle while the receiver does not stall, set
//   by the single conversion pass between the two registers.
//   While the receiver stalls, the result register holds its word and the
//   input register can still take one more word; in_tready then falls until
//   out_tready returns. in_tready depends on out_tready in the same cycle.
//   A synchronous low rst_n empties both registers; no word is lost or made
//   up afterwards.
module base4_float16_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // double_in[63:0], short_sign_in[64], short_exp_in[68:65], short_mant_in[79:69]
  input  logic [79:0] in_tdata,
  // op[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // short_sign_out[0], short_exp_out[4:1], short_mant_out[15:5], double_out[79:16]
  output logic [79:0] out_tdata
);
  import b4f16_pkg::*;

  logic                in_valid_r;
  logic [79:0]         in_data_r;
  b4f16_op_t           in_op_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [79:0]         out_data_r;
  logic [79:0]         out_data_nxt;
  logic                advance;
  logic                in_acc;
  b4f16_short_t        short_in;
  b4f16_short_t        enc_short;
  logic [63:0]         dec_dbl;

  // Flow control: the result register frees up when empty or when taken.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_acc) begin
      in_data_r <= in_tdata;
      in_op_r   <= b4f16_op_t'(in_tuser[0]);
    end
  end

  assign short_in.sign = in_data_r[64];
  assign short_in.expo = in_data_r[68:65];
  assign short_in.mant = in_data_r[79:69];

  b4f16_encoder u_enc (
    .dbl     (in_data_r[63:0]),
    .short_o (enc_short)
  );

  b4f16_decoder u_dec (
    .short_i (short_in),
    .dbl     (dec_dbl)
  );

  // Select the result of the requested operation; the other part is zero.
  always_comb begin
    case (in_op_r)
      OP_ENCODE: out_data_nxt = {64'b0, enc_short.mant, enc_short.expo, enc_short.sign};
      OP_DECODE: out_data_nxt = {dec_dbl, 16'b0};
      default:   out_data_nxt = '0;
    endcase
  end

  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance && in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // An accepted word always lands in the input register.
  a_in_load : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_valid_r)
    else $error("accepted word did not reach the input register");

  // A pending word moves into the result register when it is free.
  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && advance) |=> out_valid_r)
    else $error("pending word was dropped on its way to the result register");

  // A word held by a full result register keeps its input stage unchanged.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_data_r)))
    else $error("input register changed while the result side was stalled");

  // Only one half of a result word is ever non-zero.
  a_one_half : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[79:16] == 64'b0 || out_data_r[15:0] == 16'b0))
    else $error("result word carries both an encode and a decode part");

  // Decoded doubles always have a biased exponent within the short range.
  a_dec_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[79:16] != 64'b0) |->
      (out_data_r[78:68] >= 11'd999 && out_data_r[78:68] <= 11'd1040))
    else $error("decoded exponent out of range");
`endif

endmodule

/* tb/b4f16_result_check.sv */
// Checker for the base-4 short float codec: watches both stream channels,
// predicts each result word from the accepted input word and compares.
// Depends on b4f16_pkg for the operation codes and the short float layout.
module b4f16_result_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // double_in[63:0], short_sign_in[64], short_exp_in[68:65], short_mant_in[79:69]
  input  logic [79:0] in_tdata,
  // op[0]
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // short_sign_out[0], short_exp_out[4:1], short_mant_out[15:5], double_out[79:16]
  input  logic [79:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  import b4f16_pkg::*;

  // One predicted result word, split into its two halves.
  typedef struct packed {
    logic [DblW-1:0] dbl;
    b4f16_short_t    sfl;
  } codec_result_t;

  codec_result_t expected_words[$];

  // Works out the result word for one input word.
  function automatic codec_result_t convert_word(b4f16_op_t op, logic [79:0] d);
    codec_result_t    r;
    logic [BexpW-1:0] bexp;
    logic [FracW-1:0] frac;
    logic [FracW:0]   sig;
    logic [11:0]      q;
    logic [DblW-1:0]  shifted;
    logic [BexpW-1:0] dexp;
    int               k;
    int               p;
    r = '0;
    if (op == OP_ENCODE) begin
      bexp = d[62:52];
      frac = d[51:0];
      // NaN and both zeros give a positive zero at the offset exponent.
      if ((bexp == BEXP_SPECIAL && frac != '0) || (bexp == '0 && frac == '0)) begin
        r.sfl.expo = EXP_OFF;
      end else begin
        r.sfl.sign = d[63];
        if (bexp == BEXP_SPECIAL) begin
          // Infinity saturates like an overflow.
          r.sfl.expo = EXP_MAX;
          r.sfl.mant = MANT_MAX;
        end else if (bexp == '0) begin
          // Subnormals always fall below the short range.
          r.sfl.expo = '0;
          r.sfl.mant = MANT_UNDER;
        end else begin
          // An odd binary exponent is made even by halving the fraction.
          k = (int'(bexp) - 1022 + int'(bexp[0])) / 2 + int'(EXP_OFF);
          sig = {1'b1, frac};
          if (k > int'(EXP_MAX)) begin
            r.sfl.expo = EXP_MAX;
            r.sfl.mant = MANT_MAX;
          end else if (k < 0) begin
            r.sfl.expo = '0;
            r.sfl.mant = MANT_UNDER;
          end else begin
            r.sfl.expo = ExpW'(k);
            r.sfl.mant = MantW'(sig >> (bexp[0] ? 43 : 42));
          end
        end
      end
    end else begin
      // Mid-point of the mantissa cell, normalised on its top set bit.
      q = {d[79:69], 1'b1};
      p = 0;
      for (int i = 0; i < 12; i++) begin
        if (q[i]) p = i;
      end
      dexp = BexpW'(p + 2 * int'(d[68:65]) - 2 * int'(EXP_OFF) - 12 + 1023);
      shifted = 64'(q) << (52 - p);
      r.dbl = {d[64], dexp, shifted[51:0]};
    end
    return r;
  endfunction

  // Predict on every accepted input word, compare on every accepted result word.
  always @(posedge clk) begin
    codec_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_words.push_back(convert_word(b4f16_op_t'(in_tuser[0]), in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("result word 0x%h arrived with nothing expected", out_tdata);
          errs = errs + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_tdata[0] !== want.sfl.sign) begin
            $error("short_sign_out: expected %0d, got %0d", want.sfl.sign, out_tdata[0]);
            errs = errs + 1;
          end
          if (out_tdata[4:1] !== want.sfl.expo) begin
            $error("short_exp_out: expected %0d, got %0d", want.sfl.expo, out_tdata[4:1]);
            errs = errs + 1;
          end
          if (out_tdata[15:5] !== want.sfl.mant) begin
            $error("short_mant_out: expected %0d, got %0d", want.sfl.mant, out_tdata[15:5]);
            errs = errs + 1;
          end
          if (out_tdata[79:16] !== want.dbl) begin
            $error("double_out: expected 0x%h, got 0x%h", want.dbl, out_tdata[79:16]);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_words.size();
  end

endmodule

/* tb/tb.sv */
// Testbench top for the base-4 short float codec: clock, reset, stimulus and
// receiver stalls, with b4f16_result_check beside the block for the checking.
// Depends on b4f16_pkg, base4_float16_codec and b4f16_result_check.
module tb;
  import b4f16_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int RandomWords = 550;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          hold_req = 1'b0;
  bit          steady = 1'b0;

  base4_float16_codec DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  b4f16_result_check checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #4 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** base4_float16_codec: FAILED **");
      $finish;
    end
  end

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Encode word: the double in the low bits, random short float fields above.
  function automatic logic [79:0] enc(logic [63:0] x);
    logic [15:0] junk;
    junk = 16'($urandom);
    return {junk, x};
  endfunction

  // Decode word: the short float fields above random low bits.
  function automatic logic [79:0] dec(logic s, logic [3:0] e, logic [10:0] m);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    return {m, e, s, junk};
  endfunction

  // Offers one word and waits until it is taken, then maybe leaves a gap.
  task automatic send_word(b4f16_op_t op, logic [79:0] data, bit gapless);
    int n;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    n = gapless ? 0 : idle_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected result word has come.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request, none while steady.
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = idle_len();
        if (n == 0) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
          out_tready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    logic [79:0] data;
    logic [10:0] bexp;
    int          r;
    bit          gapless;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros, NaNs, infinities, subnormals, range edges, then decodes.
    send_word(OP_ENCODE, enc(64'h0000_0000_0000_0000), 1'b0);
    send_word(OP_ENCODE, enc(64'h8000_0000_0000_0000), 1'b0);
    send_word(OP_ENCODE, enc(64'h7FF8_0000_0000_0000), 1'b0);
    send_word(OP_ENCODE, enc(64'hFFF0_0000_0000_0001), 1'b0);
    send_word(OP_ENCODE, enc(64'h7FF0_0000_0000_0000), 1'b0);
    send_word(OP_ENCODE, enc(64'hFFF0_0000_0000_0000), 1'b0);
    send_word(OP_ENCODE, enc(64'h0000_0000_0000_0001), 1'b0);
    send_word(OP_ENCODE, enc(64'h800F_FFFF_FFFF_FFFF), 1'b0);
    send_word(OP_ENCODE, enc(64'h3FF0_0000_0000_0000), 1'b0);
    send_word(OP_ENCODE, enc(64'h7FEF_FFFF_FFFF_FFFF), 1'b0);
    send_word(OP_ENCODE, enc(64'h0010_0000_0000_0000), 1'b0);
    send_word(OP_ENCODE, enc({1'b1, 11'd1008, 52'hF_FFFF_FFFF_FFFF}), 1'b0);
    send_word(OP_ENCODE, enc({1'b0, 11'd1009, 52'h0_0000_0000_0000}), 1'b0);
    send_word(OP_ENCODE, enc({1'b1, 11'd1010, 52'hF_FFFF_FFFF_FFFF}), 1'b0);
    send_word(OP_ENCODE, enc({1'b0, 11'd1040, 52'hF_FFFF_FFFF_FFFF}), 1'b0);
    send_word(OP_ENCODE, enc({1'b1, 11'd1041, 52'h0_0000_0000_0000}), 1'b0);
    send_word(OP_ENCODE, enc({1'b0, 11'd1042, 52'hA_AAAA_AAAA_AAAA}), 1'b0);
    send_word(OP_DECODE, dec(1'b0, 4'd0, 11'd0), 1'b0);
    send_word(OP_DECODE, dec(1'b1, 4'd15, 11'd2047), 1'b0);
    send_word(OP_DECODE, dec(1'b0, 4'd6, 11'd1024), 1'b0);
    send_word(OP_DECODE, dec(1'b1, 4'd15, 11'd0), 1'b0);
    send_word(OP_DECODE, dec(1'b0, 4'd0, 11'd2047), 1'b0);
    send_word(OP_DECODE, dec(1'b1, 4'd6, 11'd1), 1'b0);
    drain();

    // Random words, mostly doubles near the short range and arbitrary short floats.
    for (int i = 0; i < RandomWords; i++) begin
      if (i == 150) hold_req = 1'b1;
      steady = (i >= 300 && i < 360);
      gapless = steady || (i >= 150 && i < 190);
      if (i == 420) drain();
      data = 80'({$urandom, $urandom, $urandom});
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) bexp = 11'($urandom_range(1000, 1050));
        else if (r < 70) bexp = ($urandom_range(0, 1) == 0) ? 11'h000 : BEXP_SPECIAL;
        else bexp = 11'($urandom);
        data[62:52] = bexp;
        if ($urandom_range(0, 7) == 0) data[51:0] = '0;
        send_word(OP_ENCODE, data, gapless);
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) data[79:69] = '0;
        else if (r == 1) data[79:69] = '1;
        else if (r == 2) data[68:65] = '0;
        else if (r == 3) data[68:65] = '1;
        send_word(OP_DECODE, data, gapless);
      end
    end
    steady = 1'b0;

    // Wait for the last results, then a few cycles more.
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** base4_float16_codec: PASSED **");
    end else begin
      $display("** base4_float16_codec: FAILED **");
    end
    $finish;
  end

endmodule

/* base4_float16_codec.f */
rtl/b4f16_pkg.sv
rtl/b4f16_encoder.sv
rtl/b4f16_decoder.sv
rtl/base4_float16_codec.sv
tb/b4f16_result_check.sv
tb/tb.sv
